// ===== rtl/traffic_clock_governor_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the traffic clock governor
// Checks are clocked on clk and held off while rst is high.
// ---------------------------------------------------------------------------
`ifndef TRAFFIC_CLOCK_GOVERNOR_ASSERT_SVH
`define TRAFFIC_CLOCK_GOVERNOR_ASSERT_SVH

// Condition that must hold at every edge.
`define TCG_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define TCG_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcg_pkg.sv =====
// ---------------------------------------------------------------------------
// tcg_pkg
// Shared constants and types for the traffic clock governor.
// ---------------------------------------------------------------------------
package tcg_pkg;

  localparam int NUM_PORTS    = 4;
  localparam int COUNTER_BITS = 32;

  localparam int SUM_BITS   = COUNTER_BITS + $clog2(NUM_PORTS);
  localparam int SCALE_BITS = 23;
  localparam int LHS_BITS   = SUM_BITS + SCALE_BITS;
  localparam int THR_BITS   = 40;
  localparam int INT_BITS   = 24;
  localparam int PCT_BITS   = 7;
  localparam int RHS_BITS   = THR_BITS + INT_BITS;
  localparam int CMP_BITS   = (LHS_BITS > RHS_BITS) ? LHS_BITS : RHS_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = THR_BITS;

  // bits per byte times microseconds per second
  localparam logic [SCALE_BITS-1:0] RATE_SCALE = SCALE_BITS'(8000000);

  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = THR_BITS'(64'd2000000000);
  localparam logic [INT_BITS-1:0] INTERVAL_RESET  = INT_BITS'(10000);
  localparam logic [PCT_BITS-1:0] PCT_RESET       = PCT_BITS'(30);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_INTERVAL  = 2'd1,
    CFG_DOWN_PCT  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    LEVEL_LOW   = 2'd0,
    LEVEL_HIGH  = 2'd1,
    LEVEL_UNSET = 2'd2
  } level_t;

  typedef logic [COUNTER_BITS-1:0] count_t;

  // registered sample stage handed to the decision stage
  typedef struct packed {
    logic                valid;
    logic                first;
    logic [SUM_BITS-1:0] sum;
    logic [PCT_BITS-1:0] draw;
  } stage_t;

endpackage

// ===== rtl/tcg_config.sv =====
// ---------------------------------------------------------------------------
// tcg_config
// Configuration registers and the registered threshold-interval product.
// ---------------------------------------------------------------------------
module tcg_config (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [tcg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [tcg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic [tcg_pkg::RHS_BITS-1:0]         rhs,
  output logic [tcg_pkg::PCT_BITS-1:0]         down_pct
);
  import tcg_pkg::*;

  logic [THR_BITS-1:0] threshold;
  logic [INT_BITS-1:0] interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      interval  <= INTERVAL_RESET;
      down_pct  <= PCT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_THRESHOLD: threshold <= cfg_data[THR_BITS-1:0];
        CFG_INTERVAL:  interval  <= cfg_data[INT_BITS-1:0];
        CFG_DOWN_PCT:  down_pct  <= cfg_data[PCT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Only changes with configuration, so one register stage is enough.
  always_ff @(posedge clk) begin
    rhs <= RHS_BITS'(threshold) * RHS_BITS'(interval);
  end

endmodule

// ===== rtl/tcg_delta.sv =====
// ---------------------------------------------------------------------------
// tcg_delta
// Takes a sample request, forms the wrapped per-port deltas and their sum.
// ---------------------------------------------------------------------------
module tcg_delta (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  tcg_pkg::count_t               counts [tcg_pkg::NUM_PORTS],
  input  logic [tcg_pkg::PCT_BITS-1:0]  draw,
  input  logic                          drain,
  output tcg_pkg::stage_t               stage
);
  import tcg_pkg::*;

  count_t              prev [NUM_PORTS];
  logic                first_sample;
  logic                accept;
  logic [SUM_BITS-1:0] sum_next;

  assign sample_stall = stage.valid && !drain;
  assign accept       = sample_valid && !sample_stall;

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      sum_next = sum_next + SUM_BITS'(count_t'(counts[i] - prev[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid  <= 1'b0;
      first_sample <= 1'b1;
    end else if (accept) begin
      stage.valid  <= 1'b1;
      first_sample <= 1'b0;
    end else if (drain) begin
      stage.valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PORTS; i++) prev[i] <= '0;
    end else if (accept) begin
      for (int i = 0; i < NUM_PORTS; i++) prev[i] <= counts[i];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.first <= first_sample;
      stage.sum   <= sum_next;
      stage.draw  <= draw;
    end
  end

endmodule

// ===== rtl/tcg_decide.sv =====
// ---------------------------------------------------------------------------
// tcg_decide
// Rate compare, level update with downshift gate, and the result register.
// ---------------------------------------------------------------------------
module tcg_decide (
  input  logic                          clk,
  input  logic                          rst,
  input  tcg_pkg::stage_t               stage,
  input  logic [tcg_pkg::RHS_BITS-1:0]  rhs,
  input  logic [tcg_pkg::PCT_BITS-1:0]  down_pct,
  input  logic                          result_stall,
  output logic                          drain,
  output logic                          result_valid,
  output logic [1:0]                    freq_select,
  output logic                          freq_changed,
  output logic                          over_threshold
);
  import tcg_pkg::*;

  level_t              level;
  level_t              level_next;
  logic                changed_next;
  logic                over_next;
  logic                want_low;
  logic [LHS_BITS-1:0] lhs;
  logic                take;

  assign drain = !result_valid || !result_stall;
  assign take  = stage.valid && drain;

  assign lhs      = LHS_BITS'(stage.sum) * LHS_BITS'(RATE_SCALE);
  assign want_low = CMP_BITS'(lhs) <= CMP_BITS'(rhs);

  always_comb begin
    level_next   = level;
    changed_next = 1'b0;
    over_next    = 1'b0;
    if (!stage.first) begin
      over_next = !want_low;
      if (!want_low) begin
        if (level != LEVEL_HIGH) begin
          level_next   = LEVEL_HIGH;
          changed_next = 1'b1;
        end
      end else if (level != LEVEL_LOW && stage.draw > down_pct) begin
        // downshift only when the draw clears the block percentage
        level_next   = LEVEL_LOW;
        changed_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= LEVEL_UNSET;
      result_valid <= 1'b0;
    end else begin
      if (take) level <= level_next;
      if (drain) result_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      freq_select    <= 2'(level_next);
      freq_changed   <= changed_next;
      over_threshold <= over_next;
    end
  end

endmodule

// ===== rtl/traffic_clock_governor.sv =====
// A sample request accepted into the delta stage register gives its result in the result register.
// Throughput: one sample per cycle while result_stall is low; the delta sum and the rate compare each take one stage.
// The threshold-interval product is registered after the config registers, so a config write passes both registers.
// Reset (rst, synchronous) restores register defaults, clears stored counters,
// marks the next sample as first and sets the level to unset.
// ---------------------------------------------------------------------------
// traffic_clock_governor
// Picks low or high clock from aggregate receive byte rate over four ports.
// ---------------------------------------------------------------------------
`include "traffic_clock_governor_assert.svh"

module traffic_clock_governor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tcg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic [tcg_pkg::COUNTER_BITS-1:0]    count_port0,
  input  logic [tcg_pkg::COUNTER_BITS-1:0]    count_port1,
  input  logic [tcg_pkg::COUNTER_BITS-1:0]    count_port2,
  input  logic [tcg_pkg::COUNTER_BITS-1:0]    count_port3,
  input  logic [tcg_pkg::PCT_BITS-1:0]        random_draw,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [1:0]                          freq_select,
  output logic                                freq_changed,
  output logic                                over_threshold
);
  import tcg_pkg::*;

  count_t              counts [NUM_PORTS];
  stage_t              stage;
  logic                drain;
  logic [RHS_BITS-1:0] rhs;
  logic [PCT_BITS-1:0] down_pct;

  assign cfg_ready = 1'b1;
  assign counts[0] = count_port0;
  assign counts[1] = count_port1;
  assign counts[2] = count_port2;
  assign counts[3] = count_port3;

  tcg_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rhs       (rhs),
    .down_pct  (down_pct)
  );

  tcg_delta u_delta (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .counts       (counts),
    .draw         (random_draw),
    .drain        (drain),
    .stage        (stage)
  );

  tcg_decide u_decide (
    .clk            (clk),
    .rst            (rst),
    .stage          (stage),
    .rhs            (rhs),
    .down_pct       (down_pct),
    .result_stall   (result_stall),
    .drain          (drain),
    .result_valid   (result_valid),
    .freq_select    (freq_select),
    .freq_changed   (freq_changed),
    .over_threshold (over_threshold)
  );

  // a change always lands on a chosen level
  `TCG_ASSERT_IMPLIES(a_change_set, result_valid && freq_changed, freq_select != 2'(LEVEL_UNSET), "level change left level unset")
  // an over-threshold change can only be an upshift
  `TCG_ASSERT_IMPLIES(a_over_high, result_valid && freq_changed && over_threshold, freq_select == 2'(LEVEL_HIGH), "over threshold change not to high")
  // input is held back only when the result stage is blocked
  `TCG_ASSERT_IMPLIES(a_stall_cause, sample_stall, result_valid && result_stall && stage.valid, "sample stalled with free result stage")

endmodule
